[design/tle_pkg.sv]
// tle_pkg: item kinds, result kinds and character codes of the tty line editor
// no dependencies; used by the top level and its checker

package tle_pkg;

  localparam logic [1:0] KIND_RX      = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_DISPLAY = 2'd2;

  localparam logic [1:0] OUT_ECHO = 2'd0;
  localparam logic [1:0] OUT_DATA = 2'd1;
  localparam logic [1:0] OUT_NONE = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_CARET = 8'h5E;

endpackage

[design/tle_ram.sv]
// tle_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/tty_line_editing_buffer.sv]
// tty_line_editing_buffer: canonical line editor over a ring buffer in one ram
// depends on tle_pkg and tle_ram
//
//  channel   ports                                   transfer
//  command   start, busy, kind_i, char_in_i,         start high, busy low
//            read_len_i
//  result    out_valid_o, out_kind_o, out_byte_o,    every cycle out_valid_o is high
//            last_o
//
// a received or display byte gives n = 1..3 results from the echo sequencer
// a read gives n = 1..MAX_READ results, one byte per cycle from the ram read port
// busy stays high until the cycle that shows the last result
// reset clears the three pointers; the line store is not cleared
// results cannot be stalled

module tty_line_editing_buffer
  import tle_pkg::*;
#(
  parameter int BUF_DEPTH = 128,
  parameter int MAX_READ  = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] kind_i,
  input  logic [7:0] char_in_i,
  input  logic [6:0] read_len_i,
  output logic       out_valid_o,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  localparam int PW = $clog2(BUF_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_EMIT, ST_READ} state_e;
  typedef logic [PW-1:0] ptr_t;

  function automatic ptr_t adv1(ptr_t p);
    if (p == PW'(BUF_DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  function automatic ptr_t dec1(ptr_t p);
    if (p == '0) begin
      return PW'(BUF_DEPTH - 1);
    end
    return p - PW'(1);
  endfunction

  state_e     state_q, state_d;
  ptr_t       head_q, head_d;
  ptr_t       cooked_q, cooked_d;
  ptr_t       raw_q, raw_d;
  logic [7:0] seq_q [3];
  logic [7:0] seq_d [3];
  logic [1:0] seq_kind_q, seq_kind_d;
  logic [1:0] seq_n_q, seq_n_d;
  logic [1:0] idx_q, idx_d;
  logic [6:0] len_q, len_d;
  logic [6:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] out_kind_q, out_kind_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       last_q, last_d;

  logic       we;
  ptr_t       waddr;
  logic [7:0] wdata;
  ptr_t       raddr;
  logic [7:0] rdata;
  logic       full, afull, stop;
  logic [6:0] len_sat;
  ptr_t       head_nx;

  tle_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign busy    = (state_q != ST_IDLE);
  assign full    = (head_q == adv1(raw_q));
  assign afull   = (head_q == adv1(adv1(raw_q)));
  assign len_sat = (read_len_i > 7'(MAX_READ)) ? 7'(MAX_READ) : read_len_i;
  assign head_nx = adv1(head_q);
  assign raddr   = (state_q == ST_READ) ? head_nx : head_q;
  assign stop    = (rdata == CH_LF) || (7'(cnt_q + 7'd1) == len_q) || (head_nx == cooked_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cooked_d    = cooked_q;
    raw_d       = raw_q;
    seq_d       = seq_q;
    seq_kind_d  = seq_kind_q;
    seq_n_d     = seq_n_q;
    idx_d       = idx_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    out_valid_d = 1'b0;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    we          = 1'b0;
    waddr       = raw_q;
    wdata       = char_in_i;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d    = ST_EMIT;
          idx_d      = 2'd0;
          seq_kind_d = OUT_NONE;
          seq_n_d    = 2'd1;
          seq_d[0]   = 8'h00;
          seq_d[1]   = 8'h00;
          seq_d[2]   = 8'h00;
          case (kind_i)
            KIND_RX: begin
              if (char_in_i == CH_BS || char_in_i == CH_DEL) begin
                if (raw_q != cooked_q) begin
                  raw_d      = dec1(raw_q);
                  seq_kind_d = OUT_ECHO;
                  seq_n_d    = 2'd3;
                  seq_d[0]   = CH_BS;
                  seq_d[1]   = CH_SP;
                  seq_d[2]   = CH_BS;
                end
              end else if (char_in_i == CH_CR || char_in_i == CH_LF) begin
                if (!full) begin
                  we         = 1'b1;
                  wdata      = CH_LF;
                  raw_d      = adv1(raw_q);
                  cooked_d   = adv1(raw_q);
                  seq_kind_d = OUT_ECHO;
                  seq_n_d    = 2'd2;
                  seq_d[0]   = CH_CR;
                  seq_d[1]   = CH_LF;
                end
              end else if (char_in_i == CH_EOT) begin
                cooked_d = raw_q;
              end else if (!full && !afull) begin
                we         = 1'b1;
                raw_d      = adv1(raw_q);
                seq_kind_d = OUT_ECHO;
                seq_d[0]   = (char_in_i == CH_ESC) ? CH_CARET : char_in_i;
              end
            end
            KIND_READ: begin
              if (len_sat != 7'd0 && head_q != cooked_q) begin
                state_d = ST_READ;
                len_d   = len_sat;
                cnt_d   = 7'd0;
              end
            end
            KIND_DISPLAY: begin
              seq_kind_d = OUT_ECHO;
              if (char_in_i == CH_CR || char_in_i == CH_LF) begin
                seq_n_d  = 2'd2;
                seq_d[0] = CH_CR;
                seq_d[1] = CH_LF;
              end else begin
                seq_d[0] = char_in_i;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_EMIT: begin
        out_valid_d = 1'b1;
        out_kind_d  = seq_kind_q;
        out_byte_d  = seq_q[idx_q];
        last_d      = (idx_q == 2'(seq_n_q - 2'd1));
        if (last_d) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        out_kind_d  = OUT_DATA;
        out_byte_d  = rdata;
        last_d      = stop;
        head_d      = head_nx;
        cnt_d       = 7'(cnt_q + 7'd1);
        if (stop) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      cooked_q    <= '0;
      raw_q       <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      seq_n_q     <= 2'd1;
      cnt_q       <= 7'd0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cooked_q    <= cooked_d;
      raw_q       <= raw_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      seq_n_q     <= seq_n_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q      <= seq_d;
    seq_kind_q <= seq_kind_d;
    len_q      <= len_d;
    out_kind_q <= out_kind_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

endmodule

[design/tle_checker.sv]
// tle_port_checker: port-level assertions on the tty line editor and its bind
// depends on tle_pkg; attaches to tty_line_editing_buffer

module tle_port_checker
  import tle_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       out_valid_o,
  input logic [1:0] out_kind_o,
  input logic [7:0] out_byte_o,
  input logic       last_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |=> !out_valid_o)
    else $error("result right after a last result");

  a_busy_until_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> busy)
    else $error("non-last result while idle");

  a_none_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == OUT_NONE |-> last_o && out_byte_o == 8'h00)
    else $error("none result not single or not zero");

  a_fall_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> out_valid_o && last_o)
    else $error("busy dropped without a last result");

endmodule

bind tty_line_editing_buffer tle_port_checker u_tle_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .out_valid_o(out_valid_o),
  .out_kind_o (out_kind_o),
  .out_byte_o (out_byte_o),
  .last_o     (last_o)
);
